>>> rtl/erb_pkg.sv
`default_nettype none

package erb_pkg;

   localparam int AngleW = 16;
   localparam int RateW  = 18;
   localparam int OutW   = 19;
   localparam int TrigW  = 16;

   // CORDIC angle word is Q3.28 and the x/y words are Q2.30 with one guard bit.
   localparam int CordicSteps = 16;
   localparam int ZW          = 32;
   localparam int XW          = 33;

   localparam logic signed [ZW-1:0] HalfPiQ28    = 32'sd421657428;
   localparam logic signed [ZW-1:0] PiQ28        = 32'sd843314857;
   localparam logic signed [XW-1:0] CordicGainQ30 = 33'sd652032874;

   localparam logic signed [ZW-1:0] AtanQ28 [CordicSteps] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
      32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
      32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192
   };

   // Width of a rounded sum before it is clamped to the output range.
   localparam int SatW = 21;

   typedef struct packed {
      logic signed [RateW-1:0] roll;
      logic signed [RateW-1:0] pitch;
      logic signed [RateW-1:0] yaw;
   } rates_type;

   typedef struct packed {
      logic signed [TrigW-1:0] sr;
      logic signed [TrigW-1:0] cr;
      logic signed [TrigW-1:0] st;
      logic signed [TrigW-1:0] ct;
   } trig_type;

   // Optional negation, round to nearest from Q.30 to Q1.15, then clamp.
   function automatic logic signed [TrigW-1:0] to_q15(input logic signed [XW-1:0] v,
                                                      input logic flip);
      logic signed [XW:0] w;
      logic signed [XW:0] t;
      w = flip ? -((XW+1)'(v)) : (XW+1)'(v);
      t = (w + (XW+1)'(1 <<< 14)) >>> 15;
      if (t > (XW+1)'(32767)) begin
         return 16'sh7fff;
      end else if (t < -((XW+1)'(32768))) begin
         return 16'sh8000;
      end
      return TrigW'(t);
   endfunction

   function automatic logic signed [OutW-1:0] sat_out(input logic signed [SatW-1:0] v);
      if (v > SatW'(262143)) begin
         return 19'sh3ffff;
      end else if (v < -(SatW'(262144))) begin
         return 19'sh40000;
      end
      return OutW'(v);
   endfunction

endpackage

`default_nettype wire

>>> rtl/erb_sincos.sv
`default_nettype none

module erb_sincos (
   input  wire  logic                                 clock,
   input  wire  logic                                 reset,
   input  wire  logic                                 in_valid,
   output logic                                       in_ready,
   input  wire  logic signed [erb_pkg::AngleW-1:0]    roll_angle,
   input  wire  logic signed [erb_pkg::AngleW-1:0]    pitch_angle,
   input  wire  erb_pkg::rates_type                   in_rates,
   output logic                                       out_valid,
   input  wire  logic                                 out_ready,
   output erb_pkg::trig_type                          out_trig,
   output erb_pkg::rates_type                         out_rates
);

   localparam int Steps  = erb_pkg::CordicSteps;
   localparam int Stages = Steps + 2;
   localparam int ZW     = erb_pkg::ZW;
   localparam int XW     = erb_pkg::XW;

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] en;

   // Stage 0 holds the reduced angle, stage k the state after k rotations.
   logic signed [ZW-1:0] z_ff [0:Steps][0:1];
   logic signed [ZW-1:0] z_in [0:Steps][0:1];
   logic signed [XW-1:0] x_ff [0:Steps][0:1];
   logic signed [XW-1:0] x_in [0:Steps][0:1];
   logic signed [XW-1:0] y_ff [0:Steps][0:1];
   logic signed [XW-1:0] y_in [0:Steps][0:1];
   logic                 flip_ff [0:Steps][0:1];
   logic                 flip_in [0:Steps][0:1];

   erb_pkg::rates_type rates_ff [0:Stages-1];
   erb_pkg::trig_type  trig_ff;
   erb_pkg::trig_type  trig_in;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      for (int k = Stages - 1; k >= 0; k--) begin
         if (k == Stages - 1) begin
            en[k] = !valid_ff[k] || out_ready;
         end else begin
            en[k] = !valid_ff[k] || en[k+1];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_trig  = trig_ff;
   assign out_rates = rates_ff[Stages-1];

   always_comb begin
      logic signed [ZW-1:0] zw;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      for (int l = 0; l < 2; l++) begin
         zw = (l == 0) ? (ZW'(roll_angle) <<< 15) : (ZW'(pitch_angle) <<< 15);
         x_in[0][l] = erb_pkg::CordicGainQ30;
         y_in[0][l] = '0;
         if (zw > erb_pkg::HalfPiQ28) begin
            z_in[0][l]    = zw - erb_pkg::PiQ28;
            flip_in[0][l] = 1'b1;
         end else if (zw < -erb_pkg::HalfPiQ28) begin
            z_in[0][l]    = zw + erb_pkg::PiQ28;
            flip_in[0][l] = 1'b1;
         end else begin
            z_in[0][l]    = zw;
            flip_in[0][l] = 1'b0;
         end
      end
      for (int k = 0; k < Steps; k++) begin
         for (int l = 0; l < 2; l++) begin
            xs = x_ff[k][l] >>> k;
            ys = y_ff[k][l] >>> k;
            flip_in[k+1][l] = flip_ff[k][l];
            if (!z_ff[k][l][ZW-1]) begin
               x_in[k+1][l] = x_ff[k][l] - ys;
               y_in[k+1][l] = y_ff[k][l] + xs;
               z_in[k+1][l] = z_ff[k][l] - erb_pkg::AtanQ28[k];
            end else begin
               x_in[k+1][l] = x_ff[k][l] + ys;
               y_in[k+1][l] = y_ff[k][l] - xs;
               z_in[k+1][l] = z_ff[k][l] + erb_pkg::AtanQ28[k];
            end
         end
      end
      trig_in.sr = erb_pkg::to_q15(y_ff[Steps][0], flip_ff[Steps][0]);
      trig_in.cr = erb_pkg::to_q15(x_ff[Steps][0], flip_ff[Steps][0]);
      trig_in.st = erb_pkg::to_q15(y_ff[Steps][1], flip_ff[Steps][1]);
      trig_in.ct = erb_pkg::to_q15(x_ff[Steps][1], flip_ff[Steps][1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (en[k]) begin
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= Steps; k++) begin
         if (en[k]) begin
            for (int l = 0; l < 2; l++) begin
               z_ff[k][l]    <= z_in[k][l];
               x_ff[k][l]    <= x_in[k][l];
               y_ff[k][l]    <= y_in[k][l];
               flip_ff[k][l] <= flip_in[k][l];
            end
         end
      end
      for (int k = 0; k < Stages; k++) begin
         if (en[k]) begin
            rates_ff[k] <= (k == 0) ? in_rates : rates_ff[k-1];
         end
      end
      if (en[Stages-1]) begin
         trig_ff <= trig_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/erb_mix.sv
`default_nettype none

module erb_mix (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   input  wire  logic                               in_valid,
   output logic                                     in_ready,
   input  wire  erb_pkg::trig_type                  in_trig,
   input  wire  erb_pkg::rates_type                 in_rates,
   output logic                                     out_valid,
   input  wire  logic                               out_ready,
   output logic signed [erb_pkg::OutW-1:0]          body_rate_x,
   output logic signed [erb_pkg::OutW-1:0]          body_rate_y,
   output logic signed [erb_pkg::OutW-1:0]          body_rate_z
);

   localparam int Stages = 3;
   localparam int RateW  = erb_pkg::RateW;
   localparam int OutW   = erb_pkg::OutW;
   localparam int SatW   = erb_pkg::SatW;
   localparam int ProdW  = 34;
   localparam int TrigPW = 32;
   localparam int WideW  = 50;
   localparam int PW     = 35;
   localparam int SumW   = 51;

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] en;

   // First products.
   logic signed [ProdW-1:0]  st_yr_ff, st_yr_in;
   logic signed [ProdW-1:0]  cr_pr_ff, cr_pr_in;
   logic signed [ProdW-1:0]  sr_pr_ff, sr_pr_in;
   logic signed [TrigPW-1:0] srct_ff, srct_in;
   logic signed [TrigPW-1:0] crct_ff, crct_in;
   logic signed [RateW-1:0]  rr_ff;
   logic signed [RateW-1:0]  yr_ff;

   // Second products and the x sum.
   logic signed [PW-1:0]     p_sum_ff, p_sum_in;
   logic signed [WideW-1:0]  q_b_ff, q_b_in;
   logic signed [WideW-1:0]  r_b_ff, r_b_in;
   logic signed [ProdW-1:0]  cr_pr2_ff;
   logic signed [ProdW-1:0]  sr_pr2_ff;

   logic signed [OutW-1:0]   x_ff, x_in;
   logic signed [OutW-1:0]   y_ff, y_in;
   logic signed [OutW-1:0]   z_ff, z_in;

   always_comb begin
      for (int k = Stages - 1; k >= 0; k--) begin
         if (k == Stages - 1) begin
            en[k] = !valid_ff[k] || out_ready;
         end else begin
            en[k] = !valid_ff[k] || en[k+1];
         end
      end
   end

   assign in_ready    = en[0];
   assign out_valid   = valid_ff[Stages-1];
   assign body_rate_x = x_ff;
   assign body_rate_y = y_ff;
   assign body_rate_z = z_ff;

   always_comb begin
      logic signed [SumW-1:0] q;
      logic signed [SumW-1:0] r;
      logic signed [SumW-1:0] qr;
      logic signed [SumW-1:0] rr;
      logic signed [PW-1:0]   pr;

      st_yr_in = ProdW'(in_trig.st) * ProdW'(in_rates.yaw);
      cr_pr_in = ProdW'(in_trig.cr) * ProdW'(in_rates.pitch);
      sr_pr_in = ProdW'(in_trig.sr) * ProdW'(in_rates.pitch);
      srct_in  = TrigPW'(in_trig.sr) * TrigPW'(in_trig.ct);
      crct_in  = TrigPW'(in_trig.cr) * TrigPW'(in_trig.ct);

      p_sum_in = (PW'(rr_ff) <<< 15) - PW'(st_yr_ff);
      q_b_in   = WideW'(srct_ff) * WideW'(yr_ff);
      r_b_in   = WideW'(crct_ff) * WideW'(yr_ff);

      // Floor shifts after adding half an LSB, so ties go toward +infinity.
      q  = (SumW'(cr_pr2_ff) <<< 15) + SumW'(q_b_ff);
      r  = SumW'(r_b_ff) - (SumW'(sr_pr2_ff) <<< 15);
      qr = (q + SumW'(1 <<< 29)) >>> 30;
      rr = (r + SumW'(1 <<< 29)) >>> 30;
      pr = (p_sum_ff + PW'(1 <<< 14)) >>> 15;
      x_in = erb_pkg::sat_out(SatW'(pr));
      y_in = erb_pkg::sat_out(SatW'(qr));
      z_in = erb_pkg::sat_out(SatW'(rr));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (en[k]) begin
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         st_yr_ff <= st_yr_in;
         cr_pr_ff <= cr_pr_in;
         sr_pr_ff <= sr_pr_in;
         srct_ff  <= srct_in;
         crct_ff  <= crct_in;
         rr_ff    <= in_rates.roll;
         yr_ff    <= in_rates.yaw;
      end
      if (en[1]) begin
         p_sum_ff  <= p_sum_in;
         q_b_ff    <= q_b_in;
         r_b_ff    <= r_b_in;
         cr_pr2_ff <= cr_pr_ff;
         sr_pr2_ff <= sr_pr_ff;
      end
      if (en[2]) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/euler_rate_to_body_rate.sv
// An accepted req word travels to rsp_valid through 21
// register stages: 18 of angle reduction, one CORDIC rotation per stage and Q1.15
// rounding, then 3 of products, sums and saturation.
// Throughput: one word per cycle while rsp_ready is high; every stage has a valid
// bit and moves whenever the stage after it is empty or moving, so bubbles close up
// under stall. Reset clears all valid bits; the data registers are not reset.
`default_nettype none

module euler_rate_to_body_rate (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   input  wire  logic                               req_valid,
   output logic                                     req_ready,
   input  wire  logic signed [erb_pkg::AngleW-1:0]  req_roll_angle,
   input  wire  logic signed [erb_pkg::AngleW-1:0]  req_pitch_angle,
   input  wire  logic signed [erb_pkg::RateW-1:0]   req_roll_rate,
   input  wire  logic signed [erb_pkg::RateW-1:0]   req_pitch_rate,
   input  wire  logic signed [erb_pkg::RateW-1:0]   req_yaw_rate,
   output logic                                     rsp_valid,
   input  wire  logic                               rsp_ready,
   output logic signed [erb_pkg::OutW-1:0]          rsp_body_rate_x,
   output logic signed [erb_pkg::OutW-1:0]          rsp_body_rate_y,
   output logic signed [erb_pkg::OutW-1:0]          rsp_body_rate_z
);

   erb_pkg::rates_type req_rates;
   erb_pkg::rates_type mid_rates;
   erb_pkg::trig_type  mid_trig;
   logic               mid_valid;
   logic               mid_ready;

   assign req_rates.roll  = req_roll_rate;
   assign req_rates.pitch = req_pitch_rate;
   assign req_rates.yaw   = req_yaw_rate;

   erb_sincos u_sincos (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .roll_angle  (req_roll_angle),
      .pitch_angle (req_pitch_angle),
      .in_rates    (req_rates),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .out_trig    (mid_trig),
      .out_rates   (mid_rates)
   );

   erb_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mid_valid),
      .in_ready    (mid_ready),
      .in_trig     (mid_trig),
      .in_rates    (mid_rates),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .body_rate_x (rsp_body_rate_x),
      .body_rate_y (rsp_body_rate_y),
      .body_rate_z (rsp_body_rate_z)
   );

endmodule

`default_nettype wire
